### hw/rtl/elsc_pkg.sv
// Shared types and constants of the ELF load segment checker.
// Used by the front end, the queue, the back end and the top level.
package elsc_pkg;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SKIPPED     = 3'd1,
		ST_FORMAT      = 3'd2,
		ST_UNSUPPORTED = 3'd3,
		ST_RANGE       = 3'd4,
		ST_ABORTED     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		K_SKIP = 2'd0,
		K_FAIL = 2'd1,
		K_SCAN = 2'd2
	} kind_t;

	localparam logic [31:0] TYPE_LOAD = 32'd1;
	localparam logic [31:0] PERM_X = 32'd1;
	localparam logic [31:0] PERM_W = 32'd2;
	localparam logic [31:0] PERM_R = 32'd4;

	localparam int FILE_LEN_W = 27;
	localparam logic [63:0] MAX_SEG_RESET = 64'd67108864;

	localparam logic [7:0] CFG_FILE_LENGTH = 8'd0;
	localparam logic [7:0] CFG_LOWEST_USER_ADDR = 8'd1;
	localparam logic [7:0] CFG_USER_ADDR_LIMIT = 8'd2;
	localparam logic [7:0] CFG_MAX_SEGMENT_BYTES = 8'd3;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PW = 2;

	typedef struct packed {
		logic [FILE_LEN_W-1:0] file_length;
		logic [63:0]           lowest_user_addr;
		logic [63:0]           user_addr_limit;
		logic [63:0]           max_segment_bytes;
	} cfg_t;

	typedef struct packed {
		logic        new_image;
		kind_t       kind;
		status_t     status;
		logic [63:0] va;
		logic [63:0] mem_end;
	} entry_t;

endpackage

### hw/rtl/elf_load_segment_checker.sv
// Skipped, aborted and early failing headers pass the front-end register, a queue slot and
// the output register; a loadable header that passes the local checks also walks the ranges
// stored so far. Throughput: one header per cycle while no scan runs and the output is not
// held back; a scan walks the range store through its single read port, one range per cycle.
// Reset clears the queue, the stored range count and the image failure at once; the
// registers return to their reset values. The range store itself needs no clearing.
module elf_load_segment_checker import elsc_pkg::*; #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// file_offset, virt_addr, file_bytes, mem_bytes, alignment, perm_flags
	input  logic [351:0]  s_tdata,
	// new_image, seg_type
	input  logic [32:0]   s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// status, zero padding
	output logic [7:0]    m_tdata,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_index,
	input  logic [63:0]   cfg_data
);

	cfg_t    cfg_q;
	logic    push_valid;
	logic    push_ready;
	entry_t  push_entry;
	logic    q_valid;
	logic    q_ready;
	entry_t  q_entry;
	status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.file_length <= '0;
			cfg_q.lowest_user_addr <= '0;
			cfg_q.user_addr_limit <= '0;
			cfg_q.max_segment_bytes <= MAX_SEG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FILE_LENGTH: cfg_q.file_length <= cfg_data[FILE_LEN_W-1:0];
				CFG_LOWEST_USER_ADDR: cfg_q.lowest_user_addr <= cfg_data;
				CFG_USER_ADDR_LIMIT: cfg_q.user_addr_limit <= cfg_data;
				CFG_MAX_SEGMENT_BYTES: cfg_q.max_segment_bytes <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	elsc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_new_image   (s_tuser[0]),
		.in_seg_type    (s_tuser[32:1]),
		.in_file_offset (s_tdata[63:0]),
		.in_virt_addr   (s_tdata[127:64]),
		.in_file_bytes  (s_tdata[191:128]),
		.in_mem_bytes   (s_tdata[255:192]),
		.in_alignment   (s_tdata[319:256]),
		.in_perm_flags  (s_tdata[351:320]),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_entry     (push_entry)
	);

	elsc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_entry (push_entry),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_entry (q_entry)
	);

	elsc_back #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_entry    (q_entry),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (status)
	);

	assign m_tdata = {5'd0, status};

endmodule

### hw/rtl/elsc_front.sv
// Front end: registers a header with its sums and flags, then classifies it.
// Depends on elsc_pkg; pushes one entry per header into the queue.
module elsc_front import elsc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_new_image,
	input  logic [31:0]   in_seg_type,
	input  logic [63:0]   in_file_offset,
	input  logic [63:0]   in_virt_addr,
	input  logic [63:0]   in_file_bytes,
	input  logic [63:0]   in_mem_bytes,
	input  logic [63:0]   in_alignment,
	input  logic [31:0]   in_perm_flags,
	output logic          push_valid,
	input  logic          push_ready,
	output entry_t        push_entry
);

	logic        valid_s1;
	logic        new_image_s1;
	logic        is_load_s1;
	logic        fsz_gt_msz_s1;
	logic        bad_flags_s1;
	logic        wx_s1;
	logic        al_bad_s1;
	logic        al_mis_s1;
	logic [64:0] file_top_s1;
	logic [64:0] mem_end_s1;
	logic [63:0] va_s1;
	logic [63:0] msz_s1;

	logic        accept;
	logic        al_gt1;
	logic [63:0] al_m1;
	logic [63:0] diff;
	status_t     status;
	kind_t       kind;

	assign in_ready = !valid_s1 || push_ready;
	assign accept = in_valid && in_ready;
	assign al_gt1 = in_alignment[63:1] != 63'd0;
	assign al_m1 = in_alignment - 64'd1;
	assign diff = in_virt_addr - in_file_offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_image_s1 <= in_new_image;
			is_load_s1 <= in_seg_type == TYPE_LOAD;
			fsz_gt_msz_s1 <= in_file_bytes > in_mem_bytes;
			bad_flags_s1 <= (in_perm_flags & ~(PERM_X | PERM_W | PERM_R)) != 32'd0;
			wx_s1 <= ((in_perm_flags & PERM_X) != 32'd0) && ((in_perm_flags & PERM_W) != 32'd0);
			al_bad_s1 <= al_gt1 && ((in_alignment & al_m1) != 64'd0);
			al_mis_s1 <= al_gt1 && ((diff & al_m1) != 64'd0);
			file_top_s1 <= {1'b0, in_file_offset} + {1'b0, in_file_bytes};
			mem_end_s1 <= {1'b0, in_virt_addr} + {1'b0, in_mem_bytes};
			va_s1 <= in_virt_addr;
			msz_s1 <= in_mem_bytes;
		end
	end

	always_comb begin
		kind = K_FAIL;
		status = ST_OK;
		priority if (!is_load_s1) begin
			kind = K_SKIP;
			status = ST_SKIPPED;
		end else if (fsz_gt_msz_s1 || bad_flags_s1) begin
			status = ST_FORMAT;
		end else if (wx_s1) begin
			status = ST_UNSUPPORTED;
		end else if (al_bad_s1 || al_mis_s1) begin
			status = ST_FORMAT;
		end else if (file_top_s1[64] ||
				file_top_s1[63:0] > {{(64-FILE_LEN_W){1'b0}}, cfg.file_length}) begin
			status = ST_RANGE;
		end else if (mem_end_s1[64]) begin
			status = ST_RANGE;
		end else if (msz_s1 != 64'd0 && (va_s1 < cfg.lowest_user_addr ||
				mem_end_s1[63:0] > cfg.user_addr_limit)) begin
			status = ST_RANGE;
		end else if (msz_s1 == 64'd0 || msz_s1 > cfg.max_segment_bytes) begin
			status = ST_UNSUPPORTED;
		end else begin
			kind = K_SCAN;
		end
	end

	assign push_valid = valid_s1;
	assign push_entry = '{new_image: new_image_s1, kind: kind, status: status,
		va: va_s1, mem_end: mem_end_s1[63:0]};

endmodule

### hw/rtl/elsc_fifo.sv
// Short queue of classified headers between the front end and the back end.
// Depends on elsc_pkg for the entry type and the depth.
module elsc_fifo import elsc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_valid,
	output logic   wr_ready,
	input  entry_t wr_entry,
	output logic   rd_valid,
	input  logic   rd_ready,
	output entry_t rd_entry
);

	entry_t               slots_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0]   wr_ptr_q;
	logic [FIFO_PW-1:0]   rd_ptr_q;
	logic [FIFO_PW:0]     fill_q;
	logic                 do_wr;
	logic                 do_rd;

	assign wr_ready = fill_q != (FIFO_PW+1)'(FIFO_DEPTH);
	assign rd_valid = fill_q != '0;
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;
	assign rd_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PW'(1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + (FIFO_PW+1)'(1);
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - (FIFO_PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

### hw/rtl/elsc_back.sv
// Back end: image state, range store with an overlap scan, and the output register.
// Depends on elsc_pkg; takes classified entries from the queue.
module elsc_back import elsc_pkg::*; #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	output logic    q_ready,
	input  entry_t  q_entry,
	output logic    out_valid,
	input  logic    out_ready,
	output status_t out_status
);

	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	logic [63:0] starts_q [MAX_SEGMENTS];
	logic [63:0] ends_q [MAX_SEGMENTS];
	logic [63:0] rd_start_q;
	logic [63:0] rd_end_q;

	state_t      state_q;
	state_t      state_d;
	logic [CW-1:0] count_q;
	logic        failed_q;
	logic [AW-1:0] idx_q;
	logic [63:0] cur_va_q;
	logic [63:0] cur_end_q;
	logic        out_valid_q;
	status_t     out_status_q;

	logic        pop;
	logic        failed_eff;
	logic [CW-1:0] count_eff;
	logic        out_load;
	status_t     out_st;
	logic        fail_set;
	logic        wr_en;
	logic [CW-1:0] wr_idx;
	logic [63:0] wr_start;
	logic [63:0] wr_end;
	logic [AW-1:0] raddr;
	logic        last;
	logic        overlap;

	assign pop = (state_q == S_IDLE) && q_valid && (!out_valid_q || out_ready);
	assign q_ready = pop;
	assign failed_eff = q_entry.new_image ? 1'b0 : failed_q;
	assign count_eff = q_entry.new_image ? '0 : count_q;
	assign last = (CW'(idx_q) + CW'(1)) == count_q;
	assign overlap = (cur_va_q < rd_end_q) && (rd_start_q < cur_end_q);

	always_comb begin
		state_d = state_q;
		out_load = 1'b0;
		out_st = ST_OK;
		fail_set = 1'b0;
		wr_en = 1'b0;
		wr_idx = count_q;
		wr_start = cur_va_q;
		wr_end = cur_end_q;
		raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (pop) begin
					priority if (failed_eff) begin
						out_load = 1'b1;
						out_st = ST_ABORTED;
					end else if (q_entry.kind == K_SKIP) begin
						out_load = 1'b1;
						out_st = ST_SKIPPED;
					end else if (q_entry.kind == K_SCAN) begin
						if (count_eff == '0) begin
							out_load = 1'b1;
							out_st = ST_OK;
							wr_en = 1'b1;
							wr_idx = '0;
							wr_start = q_entry.va;
							wr_end = q_entry.mem_end;
						end else begin
							state_d = S_SCAN;
						end
					end else begin
						out_load = 1'b1;
						out_st = q_entry.status;
						fail_set = 1'b1;
					end
				end
			end
			S_SCAN: begin
				raddr = idx_q + AW'(1);
				if (overlap) begin
					out_load = 1'b1;
					out_st = ST_FORMAT;
					fail_set = 1'b1;
					state_d = S_IDLE;
				end else if (last) begin
					out_load = 1'b1;
					state_d = S_IDLE;
					if (count_q >= CW'(MAX_SEGMENTS)) begin
						out_st = ST_UNSUPPORTED;
						fail_set = 1'b1;
					end else begin
						out_st = ST_OK;
						wr_en = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			failed_q <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				count_q <= wr_idx + CW'(1);
			end else if (pop && q_entry.new_image) begin
				count_q <= '0;
			end
			if (fail_set) begin
				failed_q <= 1'b1;
			end else if (pop && q_entry.new_image) begin
				failed_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_IDLE) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_va_q <= q_entry.va;
			cur_end_q <= q_entry.mem_end;
		end
		if (out_load) begin
			out_status_q <= out_st;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			starts_q[wr_idx[AW-1:0]] <= wr_start;
			ends_q[wr_idx[AW-1:0]] <= wr_end;
		end
		rd_start_q <= starts_q[raddr];
		rd_end_q <= ends_q[raddr];
	end

	assign out_valid = out_valid_q;
	assign out_status = out_status_q;

endmodule
